// File: rtl/core/vpi_pkg.sv
// shared constants, reset curve and handshake status type for the velocity to pwm interpolator
// no dependencies
package vpi_pkg;

	localparam int MAX_POINTS     = 4;
	localparam int DEF_NUM_POINTS = 4;
	localparam int VEL_W          = 15;
	localparam int DUTY_W         = 15;
	localparam int IN_W           = 16;
	localparam int OUT_W          = 16;
	localparam int IDX_W          = 3;
	localparam int PROD_W         = VEL_W + DUTY_W;

	// magnitude limit, 316 mm/s in q.6
	localparam logic [IN_W-1:0] VEL_LIMIT = 16'd20224;

	// register indexes of the first velocity and the first duty
	localparam logic [IDX_W-1:0] REG_POINT0_VEL  = 3'd0;
	localparam logic [IDX_W-1:0] REG_POINT0_DUTY = 3'd4;

	localparam logic [VEL_W-1:0] VEL_RST [MAX_POINTS] =
		'{15'd0, 15'd6741, 15'd13483, 15'd20224};
	localparam logic [DUTY_W-1:0] DUTY_RST [MAX_POINTS] =
		'{15'd0, 15'd5461, 15'd10923, 15'd16384};

	typedef struct packed {
		logic busy;
		logic done;
	} vpi_stat_t;

endpackage

// File: rtl/core/vpi_mul.sv
// bit-serial shift-add multiplier, one bit of the multiplier per cycle
// depends on vpi_pkg
module vpi_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vpi_pkg::VEL_W-1:0]   a,
	input  logic [vpi_pkg::DUTY_W-1:0]  b,
	output vpi_pkg::vpi_stat_t          stat,
	output logic [vpi_pkg::PROD_W-1:0]  prod
);

	localparam int CNT_W = $clog2(vpi_pkg::VEL_W + 1);

	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [vpi_pkg::DUTY_W-1:0]  b_q;
	logic [vpi_pkg::PROD_W-1:0]  prod_q;
	logic [vpi_pkg::DUTY_W:0]    sum;

	// upper half plus multiplicand when the current low bit is set
	assign sum = {1'b0, prod_q[vpi_pkg::PROD_W-1:vpi_pkg::VEL_W]}
		+ (prod_q[0] ? {1'b0, b_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(vpi_pkg::VEL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			b_q    <= b;
			prod_q <= {{vpi_pkg::DUTY_W{1'b0}}, a};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[vpi_pkg::VEL_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = prod_q;

endmodule

// File: rtl/core/vpi_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on vpi_pkg; the quotient must fit in DUTY_W bits
module vpi_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vpi_pkg::PROD_W-1:0]  dividend,
	input  logic [vpi_pkg::VEL_W-1:0]   divisor,
	output vpi_pkg::vpi_stat_t          stat,
	output logic [vpi_pkg::DUTY_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(vpi_pkg::DUTY_W + 1);

	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [vpi_pkg::VEL_W-1:0]   d_q;
	logic [vpi_pkg::VEL_W-1:0]   rem_q;
	logic [vpi_pkg::DUTY_W-1:0]  lo_q;
	logic [vpi_pkg::VEL_W:0]     r2;
	logic [vpi_pkg::VEL_W:0]     diff;
	logic                        ge;

	assign r2   = {rem_q, lo_q[vpi_pkg::DUTY_W-1]};
	assign diff = r2 - {1'b0, d_q};
	assign ge   = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(vpi_pkg::DUTY_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder stays below the divisor, so the difference fits VEL_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= divisor;
			rem_q <= dividend[vpi_pkg::PROD_W-1:vpi_pkg::DUTY_W];
			lo_q  <= dividend[vpi_pkg::DUTY_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[vpi_pkg::VEL_W-1:0] : r2[vpi_pkg::VEL_W-1:0];
			lo_q  <= {lo_q[vpi_pkg::DUTY_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = lo_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (dividend[vpi_pkg::PROD_W-1:vpi_pkg::DUTY_W] < divisor))
		else $error("divider started with a quotient wider than its register");

endmodule

// File: rtl/core/velocity_to_pwm_interpolator.sv
// top level: curve registers, segment search, control sequencer and output register
// depends on vpi_pkg, vpi_mul and vpi_div
//
// Maps a signed wheel velocity (q.6 mm/s) on s_tdata to a signed duty (q2.14) on m_tdata
// through a piecewise-linear curve of NUM_POINTS points held in cfg registers.
// s_tdata: [15:0] target_velocity. m_tdata: [15:0] duty. m_tuser: [0] range_error.
// cfg_we/cfg_index/cfg_wdata write point velocities (index 0..3) and duties (4..7);
// write only while no item is in flight.
// One item is worked at a time. An item in a sloped segment has its magnitude captured on
// acceptance, then goes through segment search, a 15-step bit-serial multiply and a 15-step
// bit-serial divide, each started by a registered pulse and ended by its done flag, and
// last the output register load. A magnitude off the curve or above the limit, or a
// zero-width last segment, skips the serial units.
// The result sits in an output register, so the next item is accepted while it waits;
// a stalled receiver holds the block only once a second result is ready.
// Reset clears the sequencer and output valid and loads the default curve.
module velocity_to_pwm_interpolator #(
	parameter int NUM_POINTS = vpi_pkg::DEF_NUM_POINTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [vpi_pkg::IN_W-1:0]    s_tdata,   // [15:0] target_velocity
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [vpi_pkg::OUT_W-1:0]   m_tdata,   // [15:0] duty
	output logic [0:0]                  m_tuser,   // [0] range_error
	input  logic                        cfg_we,
	input  logic [vpi_pkg::IDX_W-1:0]   cfg_index,
	input  logic [vpi_pkg::VEL_W-1:0]   cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	logic [vpi_pkg::VEL_W-1:0]  vel_q  [NUM_POINTS];
	logic [vpi_pkg::DUTY_W-1:0] duty_q [NUM_POINTS];

	logic                        neg_q;
	logic [vpi_pkg::IN_W-1:0]    mag_q;
	logic                        err_q;
	logic                        dn_q;
	logic [vpi_pkg::DUTY_W-1:0]  d0_q;
	logic [vpi_pkg::DUTY_W-1:0]  d1_q;
	logic [vpi_pkg::DUTY_W-1:0]  r_q;
	logic [vpi_pkg::VEL_W-1:0]   a_q;
	logic [vpi_pkg::DUTY_W-1:0]  b_q;
	logic [vpi_pkg::VEL_W-1:0]   span_q;
	logic                        mul_start_q;
	logic                        div_start_q;

	logic                        found;
	logic                        ok;
	logic                        hit;
	logic [vpi_pkg::VEL_W-1:0]   sel_v0;
	logic [vpi_pkg::VEL_W-1:0]   sel_v1;
	logic [vpi_pkg::DUTY_W-1:0]  sel_d0;
	logic [vpi_pkg::DUTY_W-1:0]  sel_d1;
	logic                        sel_dn;
	logic [vpi_pkg::IN_W-1:0]    in_mag;

	vpi_pkg::vpi_stat_t          mul_stat;
	vpi_pkg::vpi_stat_t          div_stat;
	logic [vpi_pkg::PROD_W-1:0]  prod;
	logic [vpi_pkg::DUTY_W-1:0]  quo;

	assign s_tready = (state_q == S_IDLE);
	// -32768 gives 32768, which still fits unsigned
	assign in_mag   = s_tdata[vpi_pkg::IN_W-1] ? (~s_tdata + 1'b1) : s_tdata;

	// curve registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_POINTS; p++) begin
				vel_q[p]  <= vpi_pkg::VEL_RST[p];
				duty_q[p] <= vpi_pkg::DUTY_RST[p];
			end
		end else begin
			for (int p = 0; p < NUM_POINTS; p++) begin
				if (cfg_we && cfg_index == vpi_pkg::REG_POINT0_VEL + vpi_pkg::IDX_W'(p))
					vel_q[p] <= cfg_wdata;
				if (cfg_we && cfg_index == vpi_pkg::REG_POINT0_DUTY + vpi_pkg::IDX_W'(p))
					duty_q[p] <= cfg_wdata;
			end
		end
	end

	// first segment in index order that holds the magnitude; last one closed at the top
	always_comb begin
		found  = 1'b0;
		hit    = 1'b0;
		sel_v0 = '0;
		sel_v1 = '0;
		sel_d0 = '0;
		sel_d1 = '0;
		for (int s = 0; s < NUM_POINTS - 1; s++) begin
			hit = ({1'b0, vel_q[s]} <= mag_q)
				&& ((mag_q < {1'b0, vel_q[s+1]})
				|| ((s == NUM_POINTS - 2) && (mag_q == {1'b0, vel_q[s+1]})));
			if (hit && !found) begin
				found  = 1'b1;
				sel_v0 = vel_q[s];
				sel_v1 = vel_q[s+1];
				sel_d0 = duty_q[s];
				sel_d1 = duty_q[s+1];
			end
		end
		ok     = found && (mag_q <= vpi_pkg::VEL_LIMIT);
		sel_dn = sel_d1 < sel_d0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			m_tuser     <= '0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			err_q       <= 1'b0;
			dn_q        <= 1'b0;
			d0_q        <= '0;
			d1_q        <= '0;
			r_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			span_q      <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						neg_q   <= s_tdata[vpi_pkg::IN_W-1];
						mag_q   <= in_mag;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					err_q <= !ok;
					dn_q  <= sel_dn;
					d0_q  <= sel_d0;
					d1_q  <= sel_d1;
					if (!ok) begin
						state_q <= S_DONE;
					end else if (sel_v1 == sel_v0) begin
						r_q     <= sel_d1;
						state_q <= S_DONE;
					end else begin
						a_q         <= mag_q[vpi_pkg::VEL_W-1:0] - sel_v0;
						b_q         <= sel_dn ? (sel_d0 - sel_d1) : (sel_d1 - sel_d0);
						span_q      <= sel_v1 - sel_v0;
						mul_start_q <= 1'b1;
						state_q     <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_stat.done) begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						r_q     <= dn_q ? (d0_q - quo) : (d0_q + quo);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tuser  <= err_q;
						if (err_q)
							m_tdata <= '0;
						else if (neg_q)
							m_tdata <= '0 - {1'b0, r_q};
						else
							m_tdata <= {1'b0, r_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	vpi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (a_q),
		.b      (b_q),
		.stat   (mul_stat),
		.prod   (prod)
	);

	vpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod),
		.divisor  (span_q),
		.stat     (div_stat),
		.quotient (quo)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
		else $error("range error item carries a non-zero duty");

	a_between: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !err_q)
		|-> (dn_q ? (r_q <= d0_q && r_q >= d1_q) : (r_q >= d0_q && r_q <= d1_q)))
		else $error("interpolated duty outside its segment");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == S_MUL))
		else $error("multiplier finished outside the multiply phase");

	// the two serial units work strictly one after the other
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && div_stat.busy))
		else $error("multiplier and divider busy together");

endmodule

// File: tb/tb_velocity_to_pwm_interpolator.sv
// self-checking bench for velocity_to_pwm_interpolator: queued stream driver, monitor and curve predictor
// depends on vpi_pkg and the velocity_to_pwm_interpolator rtl
module tb_velocity_to_pwm_interpolator;

	localparam int NUM_PTS    = vpi_pkg::DEF_NUM_POINTS;
	localparam int HOLD_LEN   = 500;
	localparam int STALL_MAX  = 6000;
	localparam int PHASE_LEN  = 210;
	localparam int NUM_PHASES = 8;

	typedef struct packed {
		logic [vpi_pkg::OUT_W-1:0] duty;
		logic                      range_error;
	} duty_result_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	logic [vpi_pkg::IN_W-1:0]     s_tdata   = '0;
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	logic [vpi_pkg::OUT_W-1:0]    m_tdata;
	logic [0:0]                   m_tuser;
	logic                         cfg_we    = 1'b0;
	logic [vpi_pkg::IDX_W-1:0]    cfg_index = '0;
	logic [vpi_pkg::VEL_W-1:0]    cfg_wdata = '0;

	logic [vpi_pkg::VEL_W-1:0]    curve_vel  [vpi_pkg::MAX_POINTS];
	logic [vpi_pkg::DUTY_W-1:0]   curve_duty [vpi_pkg::MAX_POINTS];

	logic [vpi_pkg::IN_W-1:0]     velocity_q [$];
	duty_result_t                 duty_expected_q [$];

	int                  send_idle = 14;
	int                  recv_idle = 65;
	int                  hold_req  = 0;
	int                  hold_seen;
	int                  hold_left;
	int                  stall_cycles = 0;
	int                  fail_count   = 0;

	velocity_to_pwm_interpolator #(.NUM_POINTS(NUM_PTS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// piecewise-linear lookup, first matching segment wins, last segment closed at the top
	function automatic duty_result_t predict_duty(logic [vpi_pkg::IN_W-1:0] velocity);
		duty_result_t res;
		int unsigned  mag;
		longint       v0, v1, d0, d1, r;
		int           seg;
		bit           found;
		mag = velocity[vpi_pkg::IN_W-1] ? (32'h10000 - 32'(velocity)) : 32'(velocity);
		res.duty = '0;
		res.range_error = 1'b1;
		found = 1'b0;
		r = 0;
		if (mag <= 32'(vpi_pkg::VEL_LIMIT)) begin
			for (seg = 0; seg <= NUM_PTS - 2; seg++) begin
				v0 = longint'(curve_vel[seg]);
				v1 = longint'(curve_vel[seg+1]);
				d0 = longint'(curve_duty[seg]);
				d1 = longint'(curve_duty[seg+1]);
				if (!found && v0 <= mag && (mag < v1 || (seg == NUM_PTS - 2 && mag == v1))) begin
					found = 1'b1;
					// zero-width segment takes the upper point's duty
					if (v1 - v0 <= 0)
						r = d1;
					else
						r = d0 + ((longint'(mag) - v0) * (d1 - d0)) / (v1 - v0);
				end
			end
		end
		if (found) begin
			res.range_error = 1'b0;
			res.duty = velocity[vpi_pkg::IN_W-1] ? 16'(-r) : 16'(r);
		end
		return res;
	endfunction

	function automatic logic [vpi_pkg::IN_W-1:0] random_velocity();
		int                       sel;
		int                       m;
		logic [vpi_pkg::IN_W-1:0] v;
		sel = $urandom_range(99);
		if (sel < 45)
			m = $urandom_range(0, 20224);
		else if (sel < 65)
			m = int'(curve_vel[$urandom_range(NUM_PTS - 1)]) + int'($urandom_range(2)) - 1;
		else if (sel < 88)
			m = -1;
		else if (sel < 94)
			m = int'(vpi_pkg::VEL_LIMIT) + int'($urandom_range(2)) - 1;
		else
			m = $urandom_range(0, 3);
		if (m < 0)
			v = 16'($urandom);
		else
			v = $urandom_range(1) ? 16'(-m) : 16'(m);
		if (sel == 99)
			v = $urandom_range(1) ? 16'h8000 : 16'h7fff;
		return v;
	endfunction

	// sender: a new item goes out once the previous one has been taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				duty_expected_q.push_back(predict_duty(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (velocity_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tdata  <= velocity_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_duty();
		duty_result_t exp_res;
		if (duty_expected_q.size() == 0) begin
			$error("unexpected item: duty %0d range_error %0b", $signed(m_tdata), m_tuser[0]);
			fail_count++;
		end else begin
			exp_res = duty_expected_q.pop_front();
			if (m_tdata !== exp_res.duty) begin
				$error("duty: expected %0d, actual %0d", $signed(exp_res.duty), $signed(m_tdata));
				fail_count++;
			end
			if (m_tuser[0] !== exp_res.range_error) begin
				$error("range_error: expected %0b, actual %0b", exp_res.range_error, m_tuser[0]);
				fail_count++;
			end
		end
	endtask

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_duty();
			if (hold_seen != hold_req) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_LEN;
				m_tready  <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("[velocity_to_pwm_interpolator] ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [vpi_pkg::IDX_W-1:0] idx, logic [vpi_pkg::VEL_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx < vpi_pkg::REG_POINT0_DUTY)
			curve_vel[idx - vpi_pkg::REG_POINT0_VEL] = value;
		else
			curve_duty[idx - vpi_pkg::REG_POINT0_DUTY] = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (velocity_q.size() > 0 || s_tvalid || duty_expected_q.size() > 0)
			@(posedge clk);
	endtask

	task automatic apply_curve(int k);
		logic [vpi_pkg::VEL_W-1:0]  v [vpi_pkg::MAX_POINTS];
		logic [vpi_pkg::DUTY_W-1:0] d [vpi_pkg::MAX_POINTS];
		logic [vpi_pkg::VEL_W-1:0]  t;
		int                         i, j;
		for (i = 0; i < vpi_pkg::MAX_POINTS; i++) begin
			v[i] = 15'($urandom_range(0, 20224));
			d[i] = 15'($urandom_range(0, 16384));
		end
		case (k)
			1: begin
				// full-width duties, top point beyond the magnitude limit
				v = '{15'd0, 15'd10000, 15'd20000, 15'd32767};
				d = '{15'd32767, 15'd0, 15'd32767, 15'd32767};
			end
			2: begin
				v = '{default: 15'd0};
				d = '{default: 15'd16384};
			end
			3: begin
				v = '{15'd10000, 15'd5000, 15'd15000, 15'd20224};
				d = '{15'd16384, 15'd0, 15'd8000, 15'd100};
			end
			5: begin
				v = '{default: 15'd20224};
				d = '{15'd16384, 15'd0, 15'd1, 15'd2};
			end
			7: begin
				v = vpi_pkg::VEL_RST;
				d = vpi_pkg::DUTY_RST;
			end
			default: begin
				if (k == 4) begin
					// gaps below the first and above the last point
					v[0] = 15'($urandom_range(1, 5000));
					v[3] = 15'($urandom_range(15000, 20223));
				end else if ($urandom_range(1)) begin
					v[0] = 15'd0;
					v[3] = 15'd20224;
				end
				for (i = 0; i < vpi_pkg::MAX_POINTS; i++)
					for (j = 0; j < vpi_pkg::MAX_POINTS - 1 - i; j++)
						if (v[j] > v[j+1]) begin
							t = v[j];
							v[j] = v[j+1];
							v[j+1] = t;
						end
			end
		endcase
		for (i = 0; i < vpi_pkg::MAX_POINTS; i++) begin
			write_reg(vpi_pkg::REG_POINT0_VEL + vpi_pkg::IDX_W'(i), v[i]);
			write_reg(vpi_pkg::REG_POINT0_DUTY + vpi_pkg::IDX_W'(i), d[i]);
		end
	endtask

	initial begin
		logic [vpi_pkg::IN_W-1:0] directed [];
		int p, n;
		directed = '{16'd0, 16'd1, 16'hffff, 16'd20224, -16'sd20224,
			16'd20225, -16'sd20225, 16'h7fff, 16'h8000, 16'h8001, 16'd6741, -16'sd6741,
			16'd6740, 16'd13483, 16'd13482, -16'sd13483, 16'd10000, -16'sd10000,
			16'd20223, 16'd100};
		curve_vel  = vpi_pkg::VEL_RST;
		curve_duty = vpi_pkg::DUTY_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			velocity_q.push_back(directed[i]);
		wait_drained();
		for (p = 0; p < NUM_PHASES; p++) begin
			apply_curve(p);
			@(posedge clk);
			send_idle <= (p < 3) ? 14 : (p < 6) ? 65 : 0;
			recv_idle <= (p < 3) ? 65 : (p < 6) ? 14 : 0;
			for (n = 0; n < PHASE_LEN; n++) begin
				velocity_q.push_back(random_velocity());
				if (n == PHASE_LEN / 2) begin
					if (p == 1) begin
						@(posedge clk);
						hold_req <= hold_req + 1;
					end
					if (p == 4)
						wait_drained();
				end
			end
			wait_drained();
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("[velocity_to_pwm_interpolator] OK");
		else
			$display("[velocity_to_pwm_interpolator] ERROR");
		$finish;
	end

endmodule
